// File: src/gwmu_pkg.sv
// ============================================================================
// gwmu_pkg: shared types and constants for the weighted moment update core
// Field widths, fixed-point limits and the request/result/snapshot structs.
// ============================================================================
`default_nettype none

package gwmu_pkg;

    // Field and accumulator widths
    localparam int INT_W  = 12;
    localparam int POST_W = 17;
    localparam int W_W    = 37;
    localparam int A_W    = 49;
    localparam int Q_W    = 61;
    localparam int MEAN_W = 20;
    localparam int VAR_W  = 32;
    localparam int MIX_W  = 17;

    // Product widths in the front pipeline
    localparam int PA_W  = POST_W + INT_W;
    localparam int ISQ_W = 2 * INT_W;
    localparam int PQ_W  = POST_W + ISQ_W;

    // Divider and scatter widths in the back end
    localparam int DVD_W     = 2 * A_W;
    localparam int DVS_W     = W_W + 1;
    localparam int C_W       = Q_W + 1;
    localparam int HALF_LO_W = (A_W + 1) / 2;
    localparam int HALF_HI_W = A_W - HALF_LO_W;
    localparam int MP_W      = 2 * HALF_LO_W;

    // Fixed-point scaling
    localparam int MEAN_SHIFT = 8;
    localparam int MIX_SHIFT  = 16;
    localparam int VAR_SHIFT  = 8;

    localparam logic [MEAN_W-1:0] MEAN_MAX = 20'd1048320;
    localparam logic [VAR_W-1:0]  VAR_MAX  = 32'd4292870400;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [INT_W-1:0]  intensity;
        logic              in_roi;
        logic [POST_W-1:0] post_bkg;
        logic [POST_W-1:0] post_mye;
        logic              last_voxel;
    } gwmu_in_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean_bkg;
        logic [MEAN_W-1:0] mean_mye;
        logic [VAR_W-1:0]  shared_variance;
        logic [MIX_W-1:0]  mix_bkg;
        logic [MIX_W-1:0]  mix_mye;
        logic              status;
    } gwmu_out_t;

    typedef struct packed {
        logic [W_W-1:0] w_bkg;
        logic [W_W-1:0] w_mye;
        logic [A_W-1:0] a_bkg;
        logic [A_W-1:0] a_mye;
        logic [Q_W-1:0] q_bkg;
        logic [Q_W-1:0] q_mye;
    } gwmu_acc_t;

    // One finished volume: sums plus the variance mode sampled at its last voxel
    typedef struct packed {
        gwmu_acc_t acc;
        logic      mode;
    } gwmu_sums_t;

endpackage

`default_nettype wire

// File: src/gwmu_front.sv
// ============================================================================
// gwmu_front: voxel intake and moment accumulation
// Two multiply stages feed the per-class sums; a last voxel hands a snapshot
// of the sums to the queue and clears them.
// ============================================================================
`default_nettype none

module gwmu_front
    import gwmu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire gwmu_in_t   voxel,
    input  wire logic       variance_mode,
    input  wire logic       q_full,
    output logic            q_wr_en,
    output gwmu_sums_t      q_wr_data
);

    logic stall;
    logic advance;
    logic accept;

    logic              s1_valid_reg;
    logic              s1_roi_reg;
    logic              s1_last_reg;
    logic [POST_W-1:0] s1_post_bkg_reg;
    logic [POST_W-1:0] s1_post_mye_reg;
    logic [PA_W-1:0]   s1_pa_bkg_reg;
    logic [PA_W-1:0]   s1_pa_mye_reg;
    logic [ISQ_W-1:0]  s1_isq_reg;

    logic              s2_valid_reg;
    logic              s2_roi_reg;
    logic              s2_last_reg;
    logic [POST_W-1:0] s2_post_bkg_reg;
    logic [POST_W-1:0] s2_post_mye_reg;
    logic [PA_W-1:0]   s2_pa_bkg_reg;
    logic [PA_W-1:0]   s2_pa_mye_reg;
    logic [PQ_W-1:0]   s2_pq_bkg_reg;
    logic [PQ_W-1:0]   s2_pq_mye_reg;

    gwmu_acc_t acc_reg;
    gwmu_acc_t acc_next;
    gwmu_acc_t acc_add;
    gwmu_acc_t acc_upd;

    // Hold the whole pipeline while a last voxel waits for queue space
    assign stall   = s2_valid_reg && s2_last_reg && q_full;
    assign advance = !stall;
    assign full    = stall;
    assign accept  = push && advance;

    always_comb
    begin
        acc_add.w_bkg = acc_reg.w_bkg + W_W'(s2_post_bkg_reg);
        acc_add.w_mye = acc_reg.w_mye + W_W'(s2_post_mye_reg);
        acc_add.a_bkg = acc_reg.a_bkg + A_W'(s2_pa_bkg_reg);
        acc_add.a_mye = acc_reg.a_mye + A_W'(s2_pa_mye_reg);
        acc_add.q_bkg = acc_reg.q_bkg + Q_W'(s2_pq_bkg_reg);
        acc_add.q_mye = acc_reg.q_mye + Q_W'(s2_pq_mye_reg);

        acc_upd = s2_roi_reg ? acc_add : acc_reg;

        q_wr_en        = advance && s2_valid_reg && s2_last_reg;
        q_wr_data.acc  = acc_upd;
        q_wr_data.mode = variance_mode;

        acc_next = acc_reg;
        if (advance && s2_valid_reg)
        begin
            acc_next = s2_last_reg ? '0 : acc_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (advance)
            begin
                s1_valid_reg <= accept;
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_roi_reg      <= voxel.in_roi;
            s1_last_reg     <= voxel.last_voxel;
            s1_post_bkg_reg <= voxel.post_bkg;
            s1_post_mye_reg <= voxel.post_mye;
            s1_pa_bkg_reg   <= PA_W'(voxel.post_bkg) * PA_W'(voxel.intensity);
            s1_pa_mye_reg   <= PA_W'(voxel.post_mye) * PA_W'(voxel.intensity);
            s1_isq_reg      <= ISQ_W'(voxel.intensity) * ISQ_W'(voxel.intensity);

            s2_roi_reg      <= s1_roi_reg;
            s2_last_reg     <= s1_last_reg;
            s2_post_bkg_reg <= s1_post_bkg_reg;
            s2_post_mye_reg <= s1_post_mye_reg;
            s2_pa_bkg_reg   <= s1_pa_bkg_reg;
            s2_pa_mye_reg   <= s1_pa_mye_reg;
            s2_pq_bkg_reg   <= PQ_W'(s1_post_bkg_reg) * PQ_W'(s1_isq_reg);
            s2_pq_mye_reg   <= PQ_W'(s1_post_mye_reg) * PQ_W'(s1_isq_reg);
        end
    end

endmodule

`default_nettype wire

// File: src/gwmu_queue.sv
// ============================================================================
// gwmu_queue: snapshot queue between intake and result computation
// Small register queue of finished volume sums, head visible without a pop.
// ============================================================================
`default_nettype none

module gwmu_queue
    import gwmu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire gwmu_sums_t  wr_data,
    input  wire logic        rd_en,
    output gwmu_sums_t       rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gwmu_sums_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (rd_en && !wr_en)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: src/gwmu_div.sv
// ============================================================================
// gwmu_div: shared restoring divider
// One quotient bit per cycle over the full dividend width; done pulses once.
// ============================================================================
`default_nettype none

module gwmu_div
    import gwmu_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVD_W-1:0] quo_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;
    logic [DVS_W-1:0] rem_next;

    assign trial    = {rem_reg, quo_reg[DVD_W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign ge       = (trial >= {1'b0, dvs_reg});
    assign rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

// File: src/gwmu_back.sv
// ============================================================================
// gwmu_back: result sequencer
// Walks one volume snapshot through means, mixing weights, scatter and
// variance on a shared divider and multiplier, then loads the result register.
// ============================================================================
`default_nettype none

module gwmu_back
    import gwmu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_empty,
    input  wire gwmu_sums_t q_head,
    output logic            q_pop,
    input  wire logic       pop,
    output logic            empty,
    output gwmu_out_t       result
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOAD = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    typedef enum logic [2:0] {
        JOB_MEAN_BKG,
        JOB_MEAN_MYE,
        JOB_MIX_BKG,
        JOB_MIX_MYE,
        JOB_SCAT_BKG,
        JOB_SCAT_MYE,
        JOB_VAR
    } job_t;

    state_t           state_reg, state_next;
    job_t             job_reg, job_next;
    logic [1:0]       mcnt_reg, mcnt_next;
    logic [DVD_W-1:0] pp_reg, pp_next;
    logic [DVD_W-1:0] prod_reg, prod_next;
    logic [C_W-1:0]   csum_reg, csum_next;
    gwmu_out_t        work_reg, work_next;
    gwmu_out_t        res_reg, res_next;
    logic             res_valid_reg, res_valid_next;

    logic                 out_free;
    logic                 zero_w;
    logic [DVS_W-1:0]     btot;
    logic                 is_scat;
    logic [A_W-1:0]       a_sel;
    logic [Q_W-1:0]       q_sel;
    logic [HALF_LO_W-1:0] a_lo;
    logic [HALF_LO_W-1:0] a_hi;
    logic [HALF_LO_W-1:0] mul_x;
    logic [HALF_LO_W-1:0] mul_y;
    logic [MP_W-1:0]      mul_p;
    logic [DVD_W-1:0]     mul_ext;

    logic             div_start;
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;
    logic             div_done;
    logic [DVD_W-1:0] div_quo;

    logic                scat_over;
    logic [Q_W-1:0]      scat_c;

    gwmu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign empty    = !res_valid_reg;
    assign result   = res_reg;
    assign out_free = !res_valid_reg || pop;
    assign zero_w   = (q_head.acc.w_bkg == '0) || (q_head.acc.w_mye == '0);
    assign btot     = DVS_W'(q_head.acc.w_bkg) + DVS_W'(q_head.acc.w_mye);
    assign is_scat  = (job_reg == JOB_SCAT_BKG) || (job_reg == JOB_SCAT_MYE);

    // Square of the intensity sum from three half-width partial products
    assign a_sel   = (job_reg == JOB_SCAT_MYE) ? q_head.acc.a_mye : q_head.acc.a_bkg;
    assign q_sel   = (job_reg == JOB_SCAT_MYE) ? q_head.acc.q_mye : q_head.acc.q_bkg;
    assign a_lo    = a_sel[HALF_LO_W-1:0];
    assign a_hi    = HALF_LO_W'(a_sel[A_W-1:HALF_LO_W]);
    assign mul_x   = (mcnt_reg == 2'd0) ? a_lo : a_hi;
    assign mul_y   = (mcnt_reg == 2'd2) ? a_hi : a_lo;
    assign mul_p   = MP_W'(mul_x) * MP_W'(mul_y);
    assign mul_ext = DVD_W'(mul_p);

    // Scatter of one class: clamp at zero when the square term exceeds Q
    assign scat_over = (|div_quo[DVD_W-1:Q_W]) || (div_quo[Q_W-1:0] > q_sel);
    assign scat_c    = scat_over ? '0 : q_sel - div_quo[Q_W-1:0];

    always_comb
    begin
        unique case (job_reg)
            JOB_MEAN_BKG: div_dvd = DVD_W'(q_head.acc.a_bkg) << MEAN_SHIFT;
            JOB_MEAN_MYE: div_dvd = DVD_W'(q_head.acc.a_mye) << MEAN_SHIFT;
            JOB_MIX_BKG:  div_dvd = DVD_W'(q_head.acc.w_bkg) << MIX_SHIFT;
            JOB_MIX_MYE:  div_dvd = DVD_W'(q_head.acc.w_mye) << MIX_SHIFT;
            JOB_VAR:      div_dvd = DVD_W'(csum_reg) << VAR_SHIFT;
            default:      div_dvd = prod_reg + pp_reg;
        endcase

        unique case (job_reg)
            JOB_MEAN_BKG, JOB_SCAT_BKG: div_dvs = DVS_W'(q_head.acc.w_bkg);
            JOB_MEAN_MYE, JOB_SCAT_MYE: div_dvs = DVS_W'(q_head.acc.w_mye);
            JOB_VAR: div_dvs = q_head.mode ? DVS_W'(q_head.acc.w_mye) : btot;
            default: div_dvs = btot;
        endcase

        unique case (mcnt_reg)
            2'd0:    pp_next = mul_ext;
            2'd1:    pp_next = mul_ext << (HALF_LO_W + 1);
            default: pp_next = mul_ext << (2 * HALF_LO_W);
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        mcnt_next      = mcnt_reg;
        prod_next      = prod_reg;
        csum_next      = csum_reg;
        work_next      = work_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !pop;
        div_start      = 1'b0;
        q_pop          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    if (zero_w)
                    begin
                        // A class with no weight: flag it, all values zero
                        if (out_free)
                        begin
                            res_next        = '0;
                            res_next.status = 1'b1;
                            res_valid_next  = 1'b1;
                            q_pop           = 1'b1;
                        end
                    end
                    else
                    begin
                        job_next   = JOB_MEAN_BKG;
                        csum_next  = '0;
                        work_next  = '0;
                        state_next = ST_LOAD;
                    end
                end
            end

            ST_LOAD:
            begin
                if (is_scat)
                begin
                    mcnt_next  = 2'd0;
                    prod_next  = '0;
                    state_next = ST_MUL;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end

            ST_MUL:
            begin
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg != 2'd0)
                begin
                    prod_next = prod_reg + pp_reg;
                end
                if (mcnt_reg == 2'd3)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_LOAD;
                    unique case (job_reg)
                        JOB_MEAN_BKG:
                        begin
                            work_next.mean_bkg = (div_quo > DVD_W'(MEAN_MAX)) ?
                                                 MEAN_MAX : div_quo[MEAN_W-1:0];
                            job_next = JOB_MEAN_MYE;
                        end
                        JOB_MEAN_MYE:
                        begin
                            work_next.mean_mye = (div_quo > DVD_W'(MEAN_MAX)) ?
                                                 MEAN_MAX : div_quo[MEAN_W-1:0];
                            job_next = JOB_MIX_BKG;
                        end
                        JOB_MIX_BKG:
                        begin
                            work_next.mix_bkg = div_quo[MIX_W-1:0];
                            job_next = JOB_MIX_MYE;
                        end
                        JOB_MIX_MYE:
                        begin
                            work_next.mix_mye = div_quo[MIX_W-1:0];
                            // Myelin-only mode skips the background scatter
                            job_next = q_head.mode ? JOB_SCAT_MYE : JOB_SCAT_BKG;
                        end
                        JOB_SCAT_BKG:
                        begin
                            csum_next = csum_reg + C_W'(scat_c);
                            job_next  = JOB_SCAT_MYE;
                        end
                        JOB_SCAT_MYE:
                        begin
                            csum_next = csum_reg + C_W'(scat_c);
                            job_next  = JOB_VAR;
                        end
                        JOB_VAR:
                        begin
                            work_next.shared_variance = (div_quo > DVD_W'(VAR_MAX)) ?
                                                        VAR_MAX : div_quo[VAR_W-1:0];
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    res_next       = work_reg;
                    res_valid_next = 1'b1;
                    q_pop          = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= JOB_MEAN_BKG;
            mcnt_reg      <= 2'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            mcnt_reg      <= mcnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pp_reg   <= pp_next;
        prod_reg <= prod_next;
        csum_reg <= csum_next;
        work_reg <= work_next;
        res_reg  <= res_next;
    end

endmodule

`default_nettype wire

// File: src/gmm_weighted_moment_update_core.sv
// ============================================================================
// gmm_weighted_moment_update_core: two-class Gaussian mixture M-step
// Accumulates posterior-weighted moments per voxel and reports class means,
// shared variance and mixing weights once per volume.
// ============================================================================
//
// Usage
//   Voxel requests enter through push/full as a gwmu_in_t; a request is taken
//   at a clock edge with push high and full low. Voxels are taken one per
//   cycle while full is low; full rises only when a finished volume finds
//   the snapshot queue full, and then holds the intake until the result
//   sequencer frees a slot. The request flagged last_voxel closes the
//   volume. Results leave through empty/pop as a gwmu_out_t; the oldest
//   result sits on result while empty is low and is taken at an edge with
//   pop high. A last voxel passes the s1 and s2 multiply stages before its
//   snapshot enters the queue. Each volume then runs 7 divisions (6 in
//   myelin-only mode) on one restoring divider at one quotient bit per
//   cycle, and each scatter term first forms its square in the multiply
//   steps; a volume with a zero-weight class reports its error result
//   straight from the idle state, with no division, once the result
//   register is free. With a stalled receiver the held result and
//   QUEUE_DEPTH snapshots (the oldest in progress) are kept before full rises.
//   cfg_wr_en/cfg_wr_data set the variance mode; write it only while idle.
//   Reset clears the sums, the queue, the result valid flag and the mode.
//
`default_nettype none

module gmm_weighted_moment_update_core
    import gwmu_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire gwmu_in_t  voxel,
    output logic           empty,
    input  wire logic      pop,
    output gwmu_out_t      result,
    input  wire logic      cfg_wr_en,
    input  wire logic      cfg_wr_data
);

    logic       variance_mode_reg;
    logic       q_wr_en;
    gwmu_sums_t q_wr_data;
    logic       q_rd_en;
    gwmu_sums_t q_head;
    logic       q_full;
    logic       q_empty;

    // Hold the mode register; the front samples it at each last voxel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variance_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            variance_mode_reg <= cfg_wr_data;
        end
    end

    // Front: multiply pipeline and running per-class sums
    gwmu_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .voxel         (voxel),
        .variance_mode (variance_mode_reg),
        .q_full        (q_full),
        .q_wr_en       (q_wr_en),
        .q_wr_data     (q_wr_data)
    );

    // Queue of finished volumes between the two halves
    gwmu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_data (q_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Back: division sequencer and result register
    gwmu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_rd_en),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

`default_nettype wire

// File: src/gwmu_checker.sv
// ============================================================================
// gwmu_checker: port-level checks for the weighted moment update core
// Watches results for reset, hold, error encoding, mixing sum and ranges.
// ============================================================================
`default_nettype none

module gwmu_checker
    import gwmu_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      empty,
    input wire logic      pop,
    input wire gwmu_out_t result
);

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> empty)
        else $error("result queue not empty during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed or vanished");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.status |->
            result.mean_bkg == '0 && result.mean_mye == '0 &&
            result.shared_variance == '0 && result.mix_bkg == '0 &&
            result.mix_mye == '0)
        else $error("error result carries nonzero values");

    a_mix_sum: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !result.status |->
            (18'(result.mix_bkg) + 18'(result.mix_mye) == 18'd65536) ||
            (18'(result.mix_bkg) + 18'(result.mix_mye) == 18'd65535))
        else $error("mixing weights do not sum to one");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.mean_bkg <= MEAN_MAX && result.mean_mye <= MEAN_MAX &&
            result.shared_variance <= VAR_MAX)
        else $error("mean or variance above saturation limit");

endmodule

bind gmm_weighted_moment_update_core gwmu_checker u_gwmu_checker (.*);

`default_nettype wire

// File: verif/tb.sv
// ============================================================================
// tb: self-checking bench for the weighted moment update core
// Streams voxel requests through the push/full intake, keeps its own model
// of the per-class moment sums and compares every popped class estimate
// field by field. A short table of directed voxels comes first, then random
// volumes in phases that alternate the variance mode.
// ============================================================================

module tb;
    import gwmu_pkg::*;

    localparam int RANDOM_ITEMS  = 1400;
    localparam int SETTLE_CYCLES = 16;     // lets a last voxel reach the queue
    localparam int TAIL_CYCLES   = 64;
    localparam int STALL_LIMIT   = 10000;  // longest stall plus a division pass, with margin
    localparam int PRINT_CAP     = 40;

    // One row of the directed table. Where typed is set, want holds the estimate
    // read straight off the fixed-point rules; otherwise the local model decides.
    typedef struct {
        gwmu_in_t  vox;
        bit        mode;
        bit        typed;
        gwmu_out_t want;
    } stim_row_t;

    logic      clk         = 1'b0;
    logic      rst_n       = 1'b1;
    logic      push        = 1'b0;
    gwmu_in_t  voxel       = '0;
    logic      pop         = 1'b0;
    logic      cfg_wr_en   = 1'b0;
    logic      cfg_wr_data = 1'b0;
    logic      full;
    logic      empty;
    gwmu_out_t result;

    // Local copy of the moment sums and the variance mode
    logic [W_W-1:0] w_sum [2] = '{default: '0};
    logic [A_W-1:0] i_sum [2] = '{default: '0};
    logic [Q_W-1:0] q_sum [2] = '{default: '0};
    bit             mode_shadow = 1'b0;

    gwmu_out_t pending_estimates [$];
    stim_row_t stim_rows [$];

    int mismatch_count   = 0;
    int estimates_popped = 0;
    int zero_weight_seen = 0;
    int voxels_taken     = 0;
    int volumes_closed   = 0;
    int random_sent      = 0;
    int burst_left       = 0;

    // Receiver pattern: open windows of random length, stalls from a fixed plan
    int pop_left      = 0;
    int plan_idx      = 0;
    int stall_plan [8] = '{0, 2, 0, 35, 700, 1, 0, 2600};

    gmm_weighted_moment_update_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .voxel       (voxel),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Model of the moment sums
    // ------------------------------------------------------------------------

    // Class mean in Q12.8, saturated for sums that have wrapped
    function automatic logic [MEAN_W-1:0] class_mean(input int k);
        logic [63:0] q;
        q = (64'(i_sum[k]) << MEAN_SHIFT) / 64'(w_sum[k]);
        return (q > 64'(MEAN_MAX)) ? MEAN_MAX : q[MEAN_W-1:0];
    endfunction

    // One-pass scatter Q - floor(A*A/B), held at zero when negative
    function automatic logic [63:0] class_scatter(input int k);
        logic [127:0] sq;
        sq = (128'(i_sum[k]) * 128'(i_sum[k])) / 128'(w_sum[k]);
        if (sq[127:64] != '0)
            sq[63:0] = '1;
        return (sq[63:0] > 64'(q_sum[k])) ? 64'd0 : 64'(q_sum[k]) - sq[63:0];
    endfunction

    // Fold one accepted voxel into the sums; on the last voxel of a volume
    // produce the class estimate and clear the sums.
    task automatic accumulate_moments(input gwmu_in_t v, output bit closed,
                                      output gwmu_out_t est);
        logic [POST_W-1:0] post [2];
        logic [63:0]       pa;
        logic [63:0]       btot;
        logic [63:0]       den;
        logic [63:0]       scat;
        logic [127:0]      wide;
        int                k;
        post[0] = v.post_bkg;
        post[1] = v.post_mye;
        closed  = v.last_voxel;
        est     = '0;
        if (v.in_roi)
        begin
            for (k = 0; k < 2; k++)
            begin
                pa       = 64'(post[k]) * 64'(v.intensity);
                w_sum[k] = w_sum[k] + post[k];
                i_sum[k] = i_sum[k] + pa[A_W-1:0];
                q_sum[k] = q_sum[k] + Q_W'(pa * 64'(v.intensity));
            end
        end
        if (v.last_voxel)
        begin
            if (w_sum[0] == '0 || w_sum[1] == '0)
            begin
                // a class without weight: error flag, all else zero
                est.status = 1'b1;
            end
            else
            begin
                est.mean_bkg = class_mean(0);
                est.mean_mye = class_mean(1);
                btot = 64'(w_sum[0]) + 64'(w_sum[1]);
                if (mode_shadow)
                begin
                    scat = class_scatter(1);
                    den  = 64'(w_sum[1]);
                end
                else
                begin
                    scat = class_scatter(0) + class_scatter(1);
                    den  = btot;
                end
                wide = (128'(scat) << VAR_SHIFT) / 128'(den);
                if (wide[127:64] != '0)
                    wide[63:0] = '1;
                est.shared_variance = (wide[63:0] > 64'(VAR_MAX)) ? VAR_MAX
                                                                   : wide[VAR_W-1:0];
                est.mix_bkg = MIX_W'((64'(w_sum[0]) << MIX_SHIFT) / btot);
                est.mix_mye = MIX_W'((64'(w_sum[1]) << MIX_SHIFT) / btot);
            end
            for (k = 0; k < 2; k++)
            begin
                w_sum[k] = '0;
                i_sum[k] = '0;
                q_sum[k] = '0;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_estimate(input gwmu_out_t got);
        gwmu_out_t want;
        if (pending_estimates.size() == 0)
        begin
            report_mismatch($sformatf("estimate popped with none pending: %p", got));
        end
        else
        begin
            want = pending_estimates.pop_front();
            estimates_popped++;
            if (want.status)
                zero_weight_seen++;
            if (got.mean_bkg !== want.mean_bkg)
                report_mismatch($sformatf("mean_bkg got %0d want %0d",
                                          got.mean_bkg, want.mean_bkg));
            if (got.mean_mye !== want.mean_mye)
                report_mismatch($sformatf("mean_mye got %0d want %0d",
                                          got.mean_mye, want.mean_mye));
            if (got.shared_variance !== want.shared_variance)
                report_mismatch($sformatf("shared_variance got %0d want %0d",
                                          got.shared_variance, want.shared_variance));
            if (got.mix_bkg !== want.mix_bkg)
                report_mismatch($sformatf("mix_bkg got %0d want %0d",
                                          got.mix_bkg, want.mix_bkg));
            if (got.mix_mye !== want.mix_mye)
                report_mismatch($sformatf("mix_mye got %0d want %0d",
                                          got.mix_mye, want.mix_mye));
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d",
                                          got.status, want.status));
        end
    endtask

    // Pop side: check at the accepting edge, then advance the stall pattern.
    always @(posedge clk)
    begin
        if (pop && !empty)
            compare_estimate(result);
        if (pop_left > 0)
        begin
            pop_left--;
        end
        else if (pop)
        begin
            // open window over: take the next stall from the plan
            pop_left = stall_plan[plan_idx];
            plan_idx = (plan_idx + 1) % 8;
            if (pop_left > 0)
                pop <= 1'b0;
            else
                pop_left = $urandom_range(1, 60);
        end
        else
        begin
            pop      <= 1'b1;
            pop_left = $urandom_range(1, 60);
        end
    end

    // Watchdog: end the run when no request moves on either side for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TIMEOUT: no request moved for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Send one voxel request. Called at a clock edge; push may still be high
    // from the request taken at this edge. Gaps open between bursts, and a
    // zero gap keeps push high across the burst boundary.
    task automatic send_voxel(input gwmu_in_t v, input bit use_typed,
                              input gwmu_out_t typed_want);
        int        gap;
        bit        closed;
        gwmu_out_t est;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push  <= 1'b1;
        voxel <= v;
        @(posedge clk);
        // hold the request while the intake is full
        while (full)
            @(posedge clk);
        voxels_taken++;
        accumulate_moments(v, closed, est);
        if (closed)
        begin
            pending_estimates.push_back(use_typed ? typed_want : est);
            volumes_closed++;
        end
    endtask

    // Write the variance mode with the block idle: drop push, drain every
    // pending estimate, let the pipeline settle, then write.
    task automatic set_variance_mode(input bit m);
        push       <= 1'b0;
        burst_left = 0;
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mode_shadow = m;
    endtask

    function automatic void add_row(input int inten, input bit roi, input int pb,
                                    input int pm, input bit last, input bit mode,
                                    input bit typed, input int mb, input int mm,
                                    input longint vq, input int xb, input int xm,
                                    input bit st);
        stim_row_t r;
        r.vox.intensity            = INT_W'(inten);
        r.vox.in_roi               = roi;
        r.vox.post_bkg             = POST_W'(pb);
        r.vox.post_mye             = POST_W'(pm);
        r.vox.last_voxel           = last;
        r.mode                     = mode;
        r.typed                    = typed;
        r.want.mean_bkg            = MEAN_W'(mb);
        r.want.mean_mye            = MEAN_W'(mm);
        r.want.shared_variance     = VAR_W'(vq);
        r.want.mix_bkg             = MIX_W'(xb);
        r.want.mix_mye             = MIX_W'(xm);
        r.want.status              = st;
        stim_rows.push_back(r);
    endfunction

    // One random volume. Most are well formed (posteriors summing to one,
    // mostly inside the region); the rest stress the corners.
    task automatic random_volume();
        int       kind;
        int       len;
        int       i;
        bit       kill_bkg;
        gwmu_in_t v;
        kind     = $urandom_range(0, 99);
        kill_bkg = 1'($urandom_range(0, 1));
        i        = $urandom_range(0, 99);
        if (i < 70)
            len = $urandom_range(1, 24);
        else if (i < 95)
            len = $urandom_range(25, 60);
        else
            len = $urandom_range(100, 250);
        for (i = 0; i < len; i++)
        begin
            v.intensity  = INT_W'($urandom_range(0, 4095));
            v.in_roi     = ($urandom_range(0, 9) != 0);
            v.post_bkg   = POST_W'($urandom_range(0, 65536));
            v.post_mye   = 17'd65536 - v.post_bkg;
            v.last_voxel = (i == len - 1);
            if (kind >= 75 && kind < 85)
            begin
                // posteriors up to nearly two, not summing to one
                v.post_bkg = POST_W'($urandom_range(0, 131071));
                v.post_mye = POST_W'($urandom_range(0, 131071));
            end
            else if (kind >= 85 && kind < 92)
            begin
                // one class never gets weight
                if (kill_bkg)
                    v.post_bkg = '0;
                else
                    v.post_mye = '0;
            end
            else if (kind >= 92 && kind < 96)
            begin
                // last voxel outside the region, or the whole volume outside
                if (v.last_voxel || kind == 95)
                    v.in_roi = 1'b0;
            end
            else if (kind >= 96)
            begin
                // extremes only
                v.intensity = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
                v.post_bkg  = $urandom_range(0, 1) ? 17'd65536 : 17'd0;
                v.post_mye  = $urandom_range(0, 1) ? 17'd65536 : 17'd0;
            end
            send_voxel(v, 1'b0, '0);
            random_sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int phase;
        //       inten roi  pb      pm     last mode typed mean_b   mean_m   variance
        //       mix_b  mix_m  status
        // Right after reset, background without weight: error flag
        add_row(100,   1, 0,      65536,  1, 0, 1, 0,       0,       0,
                0,     0,     1);
        // Empty volume, last voxel outside the region
        add_row(0,     0, 0,      0,      1, 0, 1, 0,       0,       0,
                0,     0,     1);
        // Single full-scale voxel, split weight: means at the top, no scatter
        add_row(4095,  1, 32768,  32768,  1, 0, 1, 1048320, 1048320, 0,
                32768, 32768, 0);
        // Zero intensity, both posteriors at one
        add_row(0,     1, 65536,  65536,  1, 0, 1, 0,       0,       0,
                32768, 32768, 0);
        // Two extremes, pooled variance
        add_row(0,     1, 65536,  65536,  0, 0, 0, 0,       0,       0,
                0,     0,     0);
        add_row(4095,  1, 65536,  65536,  1, 0, 1, 524160,  524160,  1073217600,
                32768, 32768, 0);
        // Last voxel outside the region still closes the volume
        add_row(2000,  1, 40000,  25536,  0, 0, 0, 0,       0,       0,
                0,     0,     0);
        add_row(4095,  0, 131071, 131071, 1, 0, 0, 0,       0,       0,
                0,     0,     0);
        // Posteriors above one, with an ignored voxel in between
        add_row(1234,  1, 131071, 131071, 0, 0, 0, 0,       0,       0,
                0,     0,     0);
        add_row(4095,  1, 131071, 0,      0, 0, 0, 0,       0,       0,
                0,     0,     0);
        add_row(0,     0, 131071, 131071, 0, 0, 0, 0,       0,       0,
                0,     0,     0);
        add_row(777,   1, 0,      131071, 1, 0, 0, 0,       0,       0,
                0,     0,     0);
        // Alternating bit patterns
        add_row(2730,  1, 87381,  43690,  0, 0, 0, 0,       0,       0,
                0,     0,     0);
        add_row(1365,  1, 43690,  87381,  1, 0, 0, 0,       0,       0,
                0,     0,     0);
        // Myelin-only variance
        add_row(3000,  1, 50000,  15536,  0, 1, 0, 0,       0,       0,
                0,     0,     0);
        add_row(500,   1, 10000,  55536,  0, 1, 0, 0,       0,       0,
                0,     0,     0);
        add_row(4095,  1, 0,      65536,  1, 1, 0, 0,       0,       0,
                0,     0,     0);
        // Myelin without weight in myelin-only mode: error flag
        add_row(4095,  1, 65536,  0,      1, 1, 1, 0,       0,       0,
                0,     0,     1);
        add_row(0,     1, 65536,  65536,  0, 1, 0, 0,       0,       0,
                0,     0,     0);
        add_row(4095,  1, 65536,  65536,  1, 1, 1, 524160,  524160,  1073217600,
                32768, 32768, 0);
        // Smallest nonzero weights
        add_row(4095,  1, 1,      1,      1, 1, 1, 1048320, 1048320, 0,
                32768, 32768, 0);

        // Assert reset with a falling edge before the first clock edge, hold it,
        // then release it for good.
        #1 rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; switch mode only between volumes.
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].mode != mode_shadow)
                set_variance_mode(stim_rows[i].mode);
            send_voxel(stim_rows[i].vox, stim_rows[i].typed, stim_rows[i].want);
        end

        // Random volumes in four phases, alternating pooled and myelin-only.
        for (phase = 0; phase < 4; phase++)
        begin
            set_variance_mode(phase % 2 == 1);
            while (random_sent < (phase + 1) * RANDOM_ITEMS / 4)
                random_volume();
        end

        // Drop push, drain what is pending, then let the pipeline go quiet.
        push <= 1'b0;
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d voxel requests in %0d volumes; %0d estimates popped,",
                 voxels_taken, volumes_closed, estimates_popped);
        $display("  %0d of them zero-weight errors, in both variance modes; %0d errors.",
                 zero_weight_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
